/* hdl/pffa_pkg.sv */
package pffa_pkg;

	// Field widths fixed by the interface.
	localparam int CNT_W      = 13;
	localparam int PAGE_W     = 12;
	localparam int ADDR_W     = 24;
	localparam int CNT_MAX    = (1 << CNT_W) - 1;
	localparam int PAGE_COUNT_RST = 4096;

	// Page frame size and the shift that turns a byte address into a page.
	localparam int PAGE_BYTES = 4096;
	localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);

	// Flag store organization: one memory word holds the flags of many pages.
	localparam int FLAG_W     = 3;
	localparam int SLOT_W     = 5;
	localparam int WORD_SLOTS = 1 << SLOT_W;
	localparam int WORD_W     = FLAG_W * WORD_SLOTS;

	typedef enum logic [1:0] {
		OP_ALLOC = 2'd0,
		OP_FREE  = 2'd1,
		OP_SET   = 2'd2,
		OP_QUERY = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NO_FREE = 2'd1,
		ST_RANGE   = 2'd2
	} status_t;

	typedef struct packed {
		logic broken;
		logic reserved;
		logic in_use;
	} flags_t;

endpackage

/* hdl/pffa_flag_ram.sv */
module pffa_flag_ram import pffa_pkg::*; #(
	parameter int unsigned DEPTH = 128,
	parameter int unsigned AW    = 7
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  logic [WORD_W-1:0] wdata,
	input  logic              re,
	input  logic [AW-1:0]     raddr,
	output logic [WORD_W-1:0] rdata
);

	logic [WORD_W-1:0] mem [DEPTH];
	logic [WORD_W-1:0] rdata_q;

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* hdl/pffa_first_free.sv */
module pffa_first_free import pffa_pkg::*; (
	input  logic [WORD_SLOTS-1:0] cand,
	output logic                  found,
	output logic [SLOT_W-1:0]     slot
);

	// Priority encoder: the lowest candidate slot wins.
	always_comb begin
		found = |cand;
		slot  = '0;
		for (int i = WORD_SLOTS - 1; i >= 0; i--) begin
			if (cand[i]) begin
				slot = SLOT_W'(i);
			end
		end
	end

endmodule

/* hdl/first_fit_page_frame_allocator.sv */
// First-fit page frame allocator. Three flags (in use, reserved, broken) are kept for each
// 4 KiB page frame in a single-port-write, registered-read memory that packs 32 pages per
// word. Allocate scans the memory one word per cycle from page 0 and claims the lowest page
// below the active limit (the smaller of page_count and MAX_PAGES) that is neither in use
// nor reserved; the scan reads between 1 and ceil(limit / 32) words (128 for 4096 pages).
// Free and set do one read-modify-write of a single word; query reads a single word. One
// transaction is worked on at a time; the result sits in an output register so the next
// transaction can be accepted while it waits. After reset the block clears the flag memory
// one word per cycle, ceil(MAX_PAGES / 32) words (128 at the default), and accepts no
// transaction until done; configuration writes are taken throughout. page_count must only
// be written while idle.
module first_fit_page_frame_allocator import pffa_pkg::*; #(
	parameter int unsigned MAX_PAGES = 4096
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CNT_W-1:0]  cfg_wdata,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        op,
	input  logic [PAGE_W-1:0] page_number,
	input  logic [ADDR_W-1:0] page_address,
	input  logic              set_in_use,
	input  logic              set_reserved,
	input  logic              set_broken,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        status,
	output logic [PAGE_W-1:0] result_page,
	output logic              flag_in_use,
	output logic              flag_reserved,
	output logic              flag_broken
);

	localparam int unsigned WORDS = (MAX_PAGES + WORD_SLOTS - 1) / WORD_SLOTS;
	localparam int unsigned AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int unsigned XW    = ((AW + SLOT_W > CNT_W) ? AW + SLOT_W : CNT_W) + 1;
	localparam int unsigned CAP   = (MAX_PAGES > CNT_MAX) ? CNT_MAX : MAX_PAGES;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_EVAL
	} state_t;

	state_t             state_q;
	logic [AW-1:0]      clr_q;
	logic [CNT_W-1:0]   page_count_q;
	op_t                op_q;
	logic [AW-1:0]      word_q;
	logic [SLOT_W-1:0]  slot_q;
	logic               range_err_q;
	flags_t             newf_q;
	logic [PAGE_W-1:0]  req_page_q;
	logic               out_valid_q;
	status_t            status_q;
	logic [PAGE_W-1:0]  result_page_q;
	flags_t             flags_out_q;

	logic [CNT_W-1:0]   lim;
	logic               accept;
	logic [PAGE_W-1:0]  req_page;
	logic [XW-1:0]      req_x;
	logic               req_range_err;

	logic [WORD_W-1:0]  rd_word;
	flags_t             cur [WORD_SLOTS];
	logic [WORD_SLOTS-1:0] cand;
	logic               found;
	logic [SLOT_W-1:0]  found_slot;
	logic [XW-1:0]      base;
	logic [XW-1:0]      rem;
	logic [XW-1:0]      next_base;
	logic [XW-1:0]      alloc_page;
	logic               more_words;
	logic [SLOT_W-1:0]  mod_slot;
	flags_t             new_flags;
	logic [WORD_W-1:0]  mod_word;
	logic               out_free;
	logic               finish;
	logic               scan_next;
	logic               write_back;
	status_t            fin_status;
	logic [PAGE_W-1:0]  fin_page;
	flags_t             fin_flags;

	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	logic [WORD_W-1:0]  mem_wdata;
	logic               mem_re;
	logic [AW-1:0]      mem_raddr;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_count_q <= CNT_W'(PAGE_COUNT_RST);
		end else if (cfg_we) begin
			page_count_q <= cfg_wdata;
		end
	end

	// The active limit is the smaller of the register and the store size.
	assign lim = (page_count_q > CNT_W'(CAP)) ? CNT_W'(CAP) : page_count_q;

	// Decode of an incoming transaction.
	assign in_ready      = (state_q == S_IDLE);
	assign accept        = in_valid && in_ready;
	assign req_page      = (op_t'(op) == OP_FREE) ? page_address[PAGE_SHIFT +: PAGE_W]
	                                              : page_number;
	assign req_x         = XW'(req_page);
	assign req_range_err = (req_x >= XW'(lim));

	// Unpack the word read from the flag memory.
	always_comb begin
		for (int i = 0; i < WORD_SLOTS; i++) begin
			cur[i] = flags_t'(rd_word[i*FLAG_W +: FLAG_W]);
		end
	end

	// Free candidates within the current word, limited to pages below the limit.
	assign base      = XW'({word_q, SLOT_W'(0)});
	assign rem       = XW'(lim) - base;
	assign next_base = base + XW'(WORD_SLOTS);
	assign more_words = (next_base < XW'(lim));

	always_comb begin
		for (int i = 0; i < WORD_SLOTS; i++) begin
			cand[i] = !cur[i].in_use && !cur[i].reserved && (XW'(i) < rem);
		end
	end

	pffa_first_free u_first_free (
		.cand  (cand),
		.found (found),
		.slot  (found_slot)
	);

	assign alloc_page = base + XW'(found_slot);

	// Modify step of the read-modify-write.
	assign mod_slot = (op_q == OP_ALLOC) ? found_slot : slot_q;

	always_comb begin
		new_flags = cur[mod_slot];
		unique case (op_q)
			OP_ALLOC: new_flags.in_use = 1'b1;
			OP_FREE:  new_flags = '0;
			OP_SET:   new_flags = newf_q;
			OP_QUERY: new_flags = cur[mod_slot];
			default:  new_flags = cur[mod_slot];
		endcase
		mod_word = rd_word;
		mod_word[mod_slot*FLAG_W +: FLAG_W] = new_flags;
	end

	// Outcome of the evaluate cycle.
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		finish     = 1'b0;
		scan_next  = 1'b0;
		write_back = 1'b0;
		fin_status = ST_OK;
		fin_page   = req_page_q;
		fin_flags  = new_flags;
		if (state_q == S_EVAL) begin
			priority if (range_err_q) begin
				finish     = 1'b1;
				fin_status = ST_RANGE;
				fin_flags  = '0;
			end else if (op_q == OP_ALLOC) begin
				priority if (found) begin
					finish     = 1'b1;
					write_back = 1'b1;
					fin_page   = alloc_page[PAGE_W-1:0];
				end else if (more_words) begin
					scan_next = 1'b1;
				end else begin
					finish     = 1'b1;
					fin_status = ST_NO_FREE;
					fin_page   = '0;
					fin_flags  = '0;
				end
			end else begin
				finish     = 1'b1;
				write_back = (op_q == OP_FREE) || (op_q == OP_SET);
			end
		end
	end

	// Memory port selection: clearing pass, write-back, and reads.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = word_q;
		mem_wdata = mod_word;
		if (state_q == S_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_q;
			mem_wdata = '0;
		end else if (finish && write_back && out_free) begin
			mem_we = 1'b1;
		end
	end

	assign mem_re    = accept || scan_next;
	assign mem_raddr = scan_next ? (word_q + AW'(1))
	                 : ((op_t'(op) == OP_ALLOC) ? AW'(0) : req_x[SLOT_W +: AW]);

	pffa_flag_ram #(
		.DEPTH (WORDS),
		.AW    (AW)
	) u_flag_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (rd_word)
	);

	// Control state machine and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && !(finish && out_free)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(WORDS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						state_q     <= S_EVAL;
						op_q        <= op_t'(op);
						req_page_q  <= req_page;
						range_err_q <= (op_t'(op) != OP_ALLOC) && req_range_err;
						newf_q      <= '{broken: set_broken, reserved: set_reserved,
						                 in_use: set_in_use};
						word_q      <= (op_t'(op) == OP_ALLOC) ? AW'(0) : req_x[SLOT_W +: AW];
						slot_q      <= req_x[SLOT_W-1:0];
					end
				end
				S_EVAL: begin
					if (scan_next) begin
						word_q <= word_q + AW'(1);
					end else if (finish && out_free) begin
						state_q       <= S_IDLE;
						out_valid_q   <= 1'b1;
						status_q      <= fin_status;
						result_page_q <= fin_page;
						flags_out_q   <= fin_flags;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign result_page   = result_page_q;
	assign flag_in_use   = flags_out_q.in_use;
	assign flag_reserved = flags_out_q.reserved;
	assign flag_broken   = flags_out_q.broken;

endmodule
